// ===== sv/rc4_pkg.sv =====
// Package for the RC4 stream cipher: field widths, item kinds and the
// command and status types between controller and datapath.
// Depends on nothing; every other file of the block but rc4_ram refers to it.
package rc4_pkg;

	localparam int BYTE_W = 8;
	localparam int KIND_W = 2;
	localparam int KEY_LEN_W = 9;
	localparam int SBOX_DEPTH = 256;

	localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;

	localparam logic [KIND_W-1:0] KIND_LOAD_KEY = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SCHEDULE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CIPHER = 2'd2;

	// Read address choice for the state table.
	typedef enum logic [1:0] {
		RA_N = 2'd0,
		RA_I = 2'd1,
		RA_JN = 2'd2,
		RA_T = 2'd3
	} ra_sel_t;

	// Write address choice for the state table.
	typedef enum logic [1:0] {
		WA_N = 2'd0,
		WA_I = 2'd1,
		WA_J = 2'd2
	} wa_sel_t;

	// Write data choice for the state table.
	typedef enum logic {
		WD_RD = 1'b0,
		WD_SI = 1'b1
	} wd_sel_t;

	typedef struct packed {
		logic start_sched;
		logic finish_sched;
		logic key_load;
		logic take_data;
		logic key_re;
		logic re;
		ra_sel_t ra_sel;
		logic we;
		wa_sel_t wa_sel;
		wd_sel_t wd_sel;
		logic cap_si;
		logic j_upd;
		logic add_key;
		logic step_n;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic last_n;
		logic out_busy;
	} sts_t;

endpackage

// ===== sv/rc4_in_if.sv =====
// Input item channel of the RC4 block: valid/ready plus the item fields.
// Depends on rc4_pkg for the field widths.
interface rc4_in_if;
	logic valid;
	logic ready;
	logic [rc4_pkg::KIND_W-1:0] kind;
	logic [rc4_pkg::BYTE_W-1:0] key_index;
	logic [rc4_pkg::BYTE_W-1:0] key_byte;
	logic [rc4_pkg::BYTE_W-1:0] data_in;

	modport source (output valid, kind, key_index, key_byte, data_in, input ready);
	modport sink (input valid, kind, key_index, key_byte, data_in, output ready);
endinterface

// ===== sv/rc4_out_if.sv =====
// Result channel of the RC4 block: valid/ready plus the result fields.
// Depends on rc4_pkg for the field widths.
interface rc4_out_if;
	logic valid;
	logic ready;
	logic [rc4_pkg::BYTE_W-1:0] data_out;
	logic [rc4_pkg::BYTE_W-1:0] keystream_byte;

	modport source (output valid, data_out, keystream_byte, input ready);
	modport sink (input valid, data_out, keystream_byte, output ready);
endinterface

// ===== sv/rc4_cfg_if.sv =====
// Configuration write channel of the RC4 block, carrying the key length.
// Depends on rc4_pkg for the register width.
interface rc4_cfg_if;
	logic valid;
	logic ready;
	logic [rc4_pkg::KEY_LEN_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== sv/rc4_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// A read of an address written in the same cycle returns the old contents.
module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/rc4_datapath.sv =====
// Datapath of the RC4 block: state table and key store memories, the
// indices, the key length register and the result register.
// Depends on rc4_pkg and rc4_ram; driven by rc4_ctrl commands.
module rc4_datapath #(
	parameter int KEY_STORE_DEPTH = 256,
	localparam int KIDX_W = (KEY_STORE_DEPTH > 1) ? $clog2(KEY_STORE_DEPTH) : 1
) (
	input logic clk,
	input logic arst_n,
	input rc4_pkg::cmd_t cmd,
	output rc4_pkg::sts_t sts,
	input logic [rc4_pkg::BYTE_W-1:0] key_index,
	input logic [rc4_pkg::BYTE_W-1:0] key_byte,
	input logic [rc4_pkg::BYTE_W-1:0] data_in,
	input logic cfg_valid,
	input logic [rc4_pkg::KEY_LEN_W-1:0] cfg_data,
	input logic out_ready,
	output logic out_valid,
	output logic [rc4_pkg::BYTE_W-1:0] data_out,
	output logic [rc4_pkg::BYTE_W-1:0] keystream_byte
);

	localparam logic [rc4_pkg::KEY_LEN_W-1:0] DEPTH_LEN = rc4_pkg::KEY_LEN_W'(KEY_STORE_DEPTH);

	logic [rc4_pkg::KEY_LEN_W-1:0] key_length_q;
	logic [rc4_pkg::KEY_LEN_W-1:0] len_m1;
	logic [rc4_pkg::SBOX_DEPTH-1:0] valid_q;
	logic [rc4_pkg::BYTE_W-1:0] i_q;
	logic [rc4_pkg::BYTE_W-1:0] j_q;
	logic [rc4_pkg::BYTE_W-1:0] n_q;
	logic [KIDX_W-1:0] kpos_q;
	logic [rc4_pkg::BYTE_W-1:0] si_q;
	logic [rc4_pkg::BYTE_W-1:0] din_q;

	logic [rc4_pkg::BYTE_W-1:0] raddr;
	logic [rc4_pkg::BYTE_W-1:0] waddr;
	logic [rc4_pkg::BYTE_W-1:0] wdata;
	logic [rc4_pkg::BYTE_W-1:0] ram_q;
	logic [rc4_pkg::BYTE_W-1:0] key_q;
	logic [rc4_pkg::BYTE_W-1:0] rd;
	logic [rc4_pkg::BYTE_W-1:0] j_next;

	logic rd_vld_q;
	logic byp_q;
	logic [rc4_pkg::BYTE_W-1:0] rd_addr_q;
	logic [rc4_pkg::BYTE_W-1:0] byp_data_q;

	logic key_we;

	logic out_valid_q;
	logic [rc4_pkg::BYTE_W-1:0] data_out_q;
	logic [rc4_pkg::BYTE_W-1:0] ks_q;

	// Effective key length minus one: zero counts as one, long lengths saturate.
	always_comb begin
		if (key_length_q == '0) begin
			len_m1 = '0;
		end else if (key_length_q > DEPTH_LEN) begin
			len_m1 = DEPTH_LEN - 1'b1;
		end else begin
			len_m1 = key_length_q - 1'b1;
		end
	end

	// Entries never written since the last reset or schedule read as their
	// own index; a write in the same cycle as the read is forwarded.
	assign rd = byp_q ? byp_data_q : (rd_vld_q ? ram_q : rd_addr_q);
	assign j_next = j_q + rd + (cmd.add_key ? key_q : '0);

	always_comb begin
		case (cmd.ra_sel)
			rc4_pkg::RA_N: raddr = n_q;
			rc4_pkg::RA_I: raddr = i_q;
			rc4_pkg::RA_JN: raddr = j_next;
			rc4_pkg::RA_T: raddr = si_q + rd;
			default: raddr = n_q;
		endcase
	end

	always_comb begin
		case (cmd.wa_sel)
			rc4_pkg::WA_N: waddr = n_q;
			rc4_pkg::WA_I: waddr = i_q;
			rc4_pkg::WA_J: waddr = j_q;
			default: waddr = j_q;
		endcase
	end

	assign wdata = (cmd.wd_sel == rc4_pkg::WD_SI) ? si_q : rd;

	rc4_ram #(
		.WIDTH(rc4_pkg::BYTE_W),
		.DEPTH(rc4_pkg::SBOX_DEPTH)
	) u_sbox_ram (
		.clk(clk),
		.we(cmd.we),
		.waddr(waddr),
		.wdata(wdata),
		.re(cmd.re),
		.raddr(raddr),
		.rdata(ram_q)
	);

	assign key_we = cmd.key_load && ({1'b0, key_index} < DEPTH_LEN);

	rc4_ram #(
		.WIDTH(rc4_pkg::BYTE_W),
		.DEPTH(KEY_STORE_DEPTH)
	) u_key_ram (
		.clk(clk),
		.we(key_we),
		.waddr(key_index[KIDX_W-1:0]),
		.wdata(key_byte),
		.re(cmd.key_re),
		.raddr(kpos_q),
		.rdata(key_q)
	);

	always_ff @(posedge clk) begin
		if (cmd.re) begin
			rd_vld_q <= valid_q[raddr];
			rd_addr_q <= raddr;
			byp_q <= cmd.we && (waddr == raddr);
			byp_data_q <= wdata;
		end
		if (cmd.cap_si) begin
			si_q <= rd;
		end
		if (cmd.take_data) begin
			din_q <= data_in;
		end
		if (cmd.load_out) begin
			data_out_q <= din_q ^ rd;
			ks_q <= rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= rc4_pkg::KEY_LEN_RESET;
			valid_q <= '0;
			i_q <= '0;
			j_q <= '0;
			n_q <= '0;
			kpos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				key_length_q <= cfg_data;
			end
			if (cmd.start_sched) begin
				valid_q <= '0;
			end else if (cmd.we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (cmd.start_sched || cmd.finish_sched) begin
				i_q <= '0;
				j_q <= '0;
			end else begin
				if (cmd.take_data) begin
					i_q <= i_q + 1'b1;
				end
				if (cmd.j_upd) begin
					j_q <= j_next;
				end
			end
			if (cmd.start_sched) begin
				n_q <= '0;
				kpos_q <= '0;
			end else if (cmd.step_n) begin
				n_q <= n_q + 1'b1;
				kpos_q <= (rc4_pkg::KEY_LEN_W'(kpos_q) == len_m1) ? '0 : kpos_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.last_n = (n_q == '1);
	assign sts.out_busy = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign data_out = data_out_q;
	assign keystream_byte = ks_q;

endmodule

// ===== sv/rc4_ctrl.sv =====
// Controller of the RC4 block: sequences key loads, the key schedule and
// keystream steps over the single state table memory.
// Depends on rc4_pkg; drives rc4_datapath through cmd_t.
module rc4_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [rc4_pkg::KIND_W-1:0] kind,
	output logic in_ready,
	input rc4_pkg::sts_t sts,
	output rc4_pkg::cmd_t cmd
);

	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_SCH_RD_N = 10'b00_0000_0010,
		S_SCH_RD_J = 10'b00_0000_0100,
		S_SCH_WR_N = 10'b00_0000_1000,
		S_SCH_WR_J = 10'b00_0001_0000,
		S_KS_RD_I = 10'b00_0010_0000,
		S_KS_RD_J = 10'b00_0100_0000,
		S_KS_WR_I = 10'b00_1000_0000,
		S_KS_WR_J = 10'b01_0000_0000,
		S_KS_OUT = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (kind)
						rc4_pkg::KIND_LOAD_KEY: begin
							cmd.key_load = 1'b1;
						end
						rc4_pkg::KIND_SCHEDULE: begin
							cmd.start_sched = 1'b1;
							state_d = S_SCH_RD_N;
						end
						rc4_pkg::KIND_CIPHER: begin
							cmd.take_data = 1'b1;
							state_d = S_KS_RD_I;
						end
						default: begin
						end
					endcase
				end
			end
			S_SCH_RD_N: begin
				cmd.re = 1'b1;
				cmd.ra_sel = rc4_pkg::RA_N;
				cmd.key_re = 1'b1;
				state_d = S_SCH_RD_J;
			end
			S_SCH_RD_J: begin
				cmd.cap_si = 1'b1;
				cmd.add_key = 1'b1;
				cmd.j_upd = 1'b1;
				cmd.re = 1'b1;
				cmd.ra_sel = rc4_pkg::RA_JN;
				state_d = S_SCH_WR_N;
			end
			S_SCH_WR_N: begin
				cmd.we = 1'b1;
				cmd.wa_sel = rc4_pkg::WA_N;
				cmd.wd_sel = rc4_pkg::WD_RD;
				state_d = S_SCH_WR_J;
			end
			S_SCH_WR_J: begin
				cmd.we = 1'b1;
				cmd.wa_sel = rc4_pkg::WA_J;
				cmd.wd_sel = rc4_pkg::WD_SI;
				cmd.step_n = 1'b1;
				if (sts.last_n) begin
					cmd.finish_sched = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_SCH_RD_N;
				end
			end
			S_KS_RD_I: begin
				cmd.re = 1'b1;
				cmd.ra_sel = rc4_pkg::RA_I;
				state_d = S_KS_RD_J;
			end
			S_KS_RD_J: begin
				cmd.cap_si = 1'b1;
				cmd.j_upd = 1'b1;
				cmd.re = 1'b1;
				cmd.ra_sel = rc4_pkg::RA_JN;
				state_d = S_KS_WR_I;
			end
			S_KS_WR_I: begin
				cmd.we = 1'b1;
				cmd.wa_sel = rc4_pkg::WA_I;
				cmd.wd_sel = rc4_pkg::WD_RD;
				state_d = S_KS_WR_J;
			end
			S_KS_WR_J: begin
				// The output index is read while the second half of the swap is written.
				cmd.we = 1'b1;
				cmd.wa_sel = rc4_pkg::WA_J;
				cmd.wd_sel = rc4_pkg::WD_SI;
				cmd.re = 1'b1;
				cmd.ra_sel = rc4_pkg::RA_T;
				state_d = S_KS_OUT;
			end
			S_KS_OUT: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/rc4_stream_cipher.sv =====
// Top level of the RC4 stream cipher: controller plus datapath.
// Depends on rc4_pkg, the three channel interfaces, rc4_ctrl and rc4_datapath.
//
// Usage: items arrive on the item channel (valid/ready). A load-key item
// writes one key byte into the key store. A schedule item resets the state
// table to the identity, runs the 256-step key schedule with the key repeated
// over the configured length and clears both indices; every step reads and
// writes the one state table memory twice. A cipher item runs one keystream
// step and produces one transfer on the result channel with data_out and the
// keystream byte; it makes the two reads and two writes of the swap plus the
// output read on the state table, and the next item is taken only once the
// result has been loaded into the output register.
// The key length is written on the cfg channel, which is always ready; it
// must only be written while the block is idle.
// Reset clears the indices, sets the key length to 16 and makes the state
// table read as the identity at once; the key store is undefined until loaded.
// While the receiver stalls, the finished result waits in the output
// register; a following cipher item is held in its last step until then.
module rc4_stream_cipher #(
	parameter int KEY_STORE_DEPTH = 256
) (
	input logic clk,
	input logic arst_n,
	rc4_in_if.sink item,
	rc4_out_if.source result,
	rc4_cfg_if.sink cfg
);

	rc4_pkg::cmd_t cmd;
	rc4_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	rc4_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(item.valid),
		.kind(item.kind),
		.in_ready(item.ready),
		.sts(sts),
		.cmd(cmd)
	);

	rc4_datapath #(
		.KEY_STORE_DEPTH(KEY_STORE_DEPTH)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.key_index(item.key_index),
		.key_byte(item.key_byte),
		.data_in(item.data_in),
		.cfg_valid(cfg.valid),
		.cfg_data(cfg.data),
		.out_ready(result.ready),
		.out_valid(result.valid),
		.data_out(result.data_out),
		.keystream_byte(result.keystream_byte)
	);

endmodule

// ===== sv/rc4_checker.sv =====
// Port-level checks for the RC4 block, bound to the top level.
// Depends on rc4_pkg for the item kind codes.
module rc4_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [rc4_pkg::KIND_W-1:0] kind,
	input logic out_valid,
	input logic out_ready,
	input logic [rc4_pkg::BYTE_W-1:0] data_out,
	input logic [rc4_pkg::BYTE_W-1:0] keystream_byte
);

	logic busy_kind;
	logic quick_kind;

	assign busy_kind = (kind == rc4_pkg::KIND_SCHEDULE) || (kind == rc4_pkg::KIND_CIPHER);
	assign quick_kind = !busy_kind;

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(keystream_byte))
		else $error("result changed or dropped while stalled");

	a_busy_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && busy_kind |=> !in_ready)
		else $error("block took a new item right after a schedule or cipher transfer");

	a_quick_items: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && quick_kind |=> in_ready)
		else $error("key load or unused item left the block busy");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while the block was idle");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(item.valid),
	.in_ready(item.ready),
	.kind(item.kind),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.data_out(result.data_out),
	.keystream_byte(result.keystream_byte)
);

// ===== sim/tb.sv =====
// Self-checking testbench for rc4_stream_cipher: directed and random item traffic with
// key length changes, checked against a cycle-free RC4 predictor kept in this file.
// Depends on rc4_pkg, rc4_in_if, rc4_out_if, rc4_cfg_if and the rc4_stream_cipher RTL.
`timescale 1ns / 100ps

module tb;
	import rc4_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int KEY_DEPTH = 256;
	localparam int RESET_CYCLES = 6;
	// A key schedule keeps the block busy with no transfer visible.
	localparam int SETTLE_CYCLES = 1100;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASE_ITEMS = 110;

	typedef struct packed {
		logic [BYTE_W-1:0] data_out;
		logic [BYTE_W-1:0] keystream_byte;
	} cipher_result_t;

	logic clk;
	logic arst_n;

	rc4_in_if item_ch();
	rc4_out_if result_ch();
	rc4_cfg_if cfg_ch();

	rc4_stream_cipher DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	// RC4 state as the block should hold it.
	logic [BYTE_W-1:0] perm [SBOX_DEPTH];
	logic [BYTE_W-1:0] key_mem [KEY_DEPTH];
	logic [BYTE_W-1:0] ptr_i;
	logic [BYTE_W-1:0] ptr_j;
	logic [KEY_LEN_W-1:0] key_len_shadow;

	cipher_result_t pending_results [$];
	cipher_result_t head_res;

	int unsigned send_gap_pct;
	int unsigned stall_pct;
	int unsigned err_count;
	int unsigned items_sent;
	int unsigned quiet_cycles;

	always #5 clk = ~clk;

	function automatic logic [BYTE_W-1:0] rand_byte();
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	// Advance the predicted RC4 state by one accepted item.
	function automatic void predict_item(input logic [KIND_W-1:0] kind,
		input logic [BYTE_W-1:0] kidx, input logic [BYTE_W-1:0] kbyte,
		input logic [BYTE_W-1:0] din);
		int unsigned eff_len;
		int n;
		logic [BYTE_W-1:0] jj;
		logic [BYTE_W-1:0] swap;
		logic [BYTE_W-1:0] ks;
		cipher_result_t res;
		case (kind)
			KIND_LOAD_KEY: begin
				if (kidx < KEY_DEPTH)
					key_mem[kidx] = kbyte;
			end
			KIND_SCHEDULE: begin
				eff_len = key_len_shadow;
				if (eff_len == 0)
					eff_len = 1;
				if (eff_len > KEY_DEPTH)
					eff_len = KEY_DEPTH;
				for (n = 0; n < SBOX_DEPTH; n++)
					perm[n] = BYTE_W'(n);
				jj = '0;
				for (n = 0; n < SBOX_DEPTH; n++) begin
					jj = jj + perm[n] + key_mem[n % eff_len];
					swap = perm[n];
					perm[n] = perm[jj];
					perm[jj] = swap;
				end
				ptr_i = '0;
				ptr_j = '0;
			end
			KIND_CIPHER: begin
				ptr_i = ptr_i + 8'd1;
				ptr_j = ptr_j + perm[ptr_i];
				swap = perm[ptr_i];
				perm[ptr_i] = perm[ptr_j];
				perm[ptr_j] = swap;
				ks = perm[8'(perm[ptr_i] + perm[ptr_j])];
				res.data_out = din ^ ks;
				res.keystream_byte = ks;
				pending_results.push_back(res);
			end
			default: begin
			end
		endcase
	endfunction

	task automatic send_item(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] kidx,
		input logic [BYTE_W-1:0] kbyte, input logic [BYTE_W-1:0] din);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.kind <= kind;
		item_ch.key_index <= kidx;
		item_ch.key_byte <= kbyte;
		item_ch.data_in <= din;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		predict_item(kind, kidx, kbyte, din);
		items_sent++;
	endtask

	task automatic load_key(input logic [BYTE_W-1:0] kidx, input logic [BYTE_W-1:0] kbyte);
		send_item(KIND_LOAD_KEY, kidx, kbyte, rand_byte());
	endtask

	task automatic schedule_key();
		send_item(KIND_SCHEDULE, rand_byte(), rand_byte(), rand_byte());
	endtask

	task automatic cipher_byte(input logic [BYTE_W-1:0] din);
		send_item(KIND_CIPHER, rand_byte(), rand_byte(), din);
	endtask

	// Stop sending, let every result arrive and give a running schedule time to end.
	task automatic drain_to_idle();
		item_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_key_length(input logic [KEY_LEN_W-1:0] len);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= len;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		key_len_shadow = len;
	endtask

	// Load a full key of the given length, schedule it and stream data through it,
	// with unused kinds, stray key loads and repeated schedules mixed in.
	task automatic run_session(input int unsigned len);
		int unsigned k;
		int unsigned n_bytes;
		int unsigned pick;
		drain_to_idle();
		write_key_length(KEY_LEN_W'(len));
		for (k = 0; k < len; k++)
			load_key(BYTE_W'(k), rand_byte());
		schedule_key();
		n_bytes = $urandom_range(4, 40);
		for (k = 0; k < n_bytes; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 4)
				send_item(KIND_UNUSED, rand_byte(), rand_byte(), rand_byte());
			else if (pick < 9)
				load_key(rand_byte(), rand_byte());
			else if (pick < 11)
				schedule_key();
			cipher_byte(rand_byte());
		end
	endtask

	// The table reads as the identity straight after reset.
	task automatic test_unkeyed_stream();
		cipher_byte(8'h00);
		cipher_byte(8'hFF);
		cipher_byte(8'h3C);
	endtask

	// Key schedule at the reset key length, with every kind and the field extremes.
	task automatic test_reset_length_schedule();
		int unsigned k;
		for (k = 0; k < 16; k++)
			load_key(BYTE_W'(k), (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : rand_byte());
		load_key(8'hFF, 8'hFF);
		schedule_key();
		cipher_byte(8'h00);
		send_item(KIND_UNUSED, 8'hFF, 8'hFF, 8'hFF);
		cipher_byte(8'hFF);
		// A new key byte must not disturb the running keystream.
		load_key(8'h00, 8'hA5);
		cipher_byte(8'hA5);
		send_item(KIND_UNUSED, 8'h00, 8'h00, 8'h00);
		cipher_byte(8'h5A);
	endtask

	task automatic test_key_length_extremes();
		run_session(1);
		run_session(KEY_DEPTH);
	endtask

	task automatic test_random_traffic(input int unsigned gap_pct, input int unsigned hold_pct);
		int unsigned start_count;
		int unsigned len;
		drain_to_idle();
		send_gap_pct = gap_pct;
		stall_pct = hold_pct;
		start_count = items_sent;
		run_session(1);
		while (items_sent - start_count < PHASE_ITEMS) begin
			if ($urandom_range(0, 9) < 7)
				len = $urandom_range(1, 24);
			else
				len = $urandom_range(1, 255);
			run_session(len);
		end
	endtask

	// Result checking: every transfer on the result channel is matched in order.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result data_out=%0h keystream_byte=%0h",
					result_ch.data_out, result_ch.keystream_byte);
				err_count++;
			end else begin
				head_res = pending_results.pop_front();
				if (result_ch.data_out !== head_res.data_out) begin
					$error("data_out expected %0h actual %0h",
						head_res.data_out, result_ch.data_out);
					err_count++;
				end
				if (result_ch.keystream_byte !== head_res.keystream_byte) begin
					$error("keystream_byte expected %0h actual %0h",
						head_res.keystream_byte, result_ch.keystream_byte);
					err_count++;
				end
			end
		end
		result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		int n;
		clk = 1'b0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.kind = KIND_LOAD_KEY;
		item_ch.key_index = '0;
		item_ch.key_byte = '0;
		item_ch.data_in = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = KEY_LEN_RESET;
		send_gap_pct = 0;
		stall_pct = 0;
		err_count = 0;
		items_sent = 0;
		quiet_cycles = 0;
		for (n = 0; n < SBOX_DEPTH; n++)
			perm[n] = BYTE_W'(n);
		for (n = 0; n < KEY_DEPTH; n++)
			key_mem[n] = '0;
		ptr_i = '0;
		ptr_j = '0;
		key_len_shadow = KEY_LEN_RESET;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unkeyed_stream();
		test_reset_length_schedule();
		test_key_length_extremes();
		test_random_traffic(0, 0);
		test_random_traffic(66, 0);
		test_random_traffic(0, 66);
		test_random_traffic(12, 12);
		drain_to_idle();

		if (err_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/rc4_pkg.sv
sv/rc4_in_if.sv
sv/rc4_out_if.sv
sv/rc4_cfg_if.sv
sv/rc4_ram.sv
sv/rc4_datapath.sv
sv/rc4_ctrl.sv
sv/rc4_stream_cipher.sv
sv/rc4_checker.sv
sim/tb.sv
